### design/fmbq_pkg.sv
// Shared constants and types of the front/middle/back queue.
`default_nettype none
package fmbq_pkg;

	localparam int WORD_W        = 32;
	localparam int OP_W          = 3;
	localparam int STATUS_W      = 2;
	localparam int DEPTH_DEFAULT = 64;
	// Cells whose taps are combined in the first level of the pop tree.
	localparam int GROUP_SIZE    = 8;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_MIDDLE = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_MIDDLE  = 3'd4;
	localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t        mode;
		logic [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### design/fmbq_cell.sv
// One storage cell of the queue chain: holds, loads or shifts in from a neighbor.
`default_nettype none
module fmbq_cell #(
	parameter int IDX_W = 6,
	parameter int IDX   = 0
) (
	input  wire logic                        clk,
	input  wire fmbq_pkg::cell_ctrl_t        ctrl,
	input  wire logic [IDX_W-1:0]            pos,
	input  wire logic [fmbq_pkg::WORD_W-1:0] left,
	input  wire logic [fmbq_pkg::WORD_W-1:0] right,
	output logic      [fmbq_pkg::WORD_W-1:0] word,
	output logic      [fmbq_pkg::WORD_W-1:0] tap
);
	import fmbq_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] word_next;

	always_comb begin
		word_next = word_q;
		unique case (ctrl.mode)
			CELL_INSERT: begin
				if (MY_IDX == pos) begin
					word_next = ctrl.word;
				end else if (MY_IDX > pos) begin
					word_next = left;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= pos) begin
					word_next = right;
				end
			end
			default: begin
				word_next = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_next;
	end

	// Only the cell being removed drives its word toward the pop tree.
	assign tap  = (ctrl.mode == CELL_REMOVE && MY_IDX == pos) ? word_q : '0;
	assign word = word_q;

endmodule
`default_nettype wire

### design/front_middle_back_queue_top.sv
// Top level of the front/middle/back queue: control, cell chain and pop tree.
//
// Usage: each input item carries an operation (push front, push middle,
// push back, pop front, pop middle, pop back) and a word for pushes. Every
// item produces exactly one result item with pop_value and status.
// Both channels use valid/stall; an item moves on an edge with valid high
// and stall low.
// The words sit in a row of DEPTH cells. On an accepted item every cell
// holds, loads the pushed word, or takes its left or right neighbor's word,
// so the whole row updates together and a new item can be taken each
// cycle while the receiver takes results. The removed word is collected
// through a two-level registered OR tree (groups of eight cells, then the
// groups): the group ORs are registered in the middle stage and the final
// OR in the output register.
// Throughput is one item per cycle while the receiver takes results.
// When out_stall is high the result holds; one more item can be taken
// into the middle stage, after which in_stall rises.
// Reset empties the queue at once; the cell contents are not cleared and
// are never read before being written.
`default_nettype none
module front_middle_back_queue_top #(
	parameter int DEPTH = fmbq_pkg::DEPTH_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [fmbq_pkg::OP_W-1:0]     operation,
	input  wire logic signed [fmbq_pkg::WORD_W-1:0]   push_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [fmbq_pkg::WORD_W-1:0]   pop_value,
	output logic             [fmbq_pkg::STATUS_W-1:0] status
);
	import fmbq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);
	localparam int NG = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

	logic [OW-1:0]       occ_q;
	logic [OW-1:0]       occ_next;
	logic [OW-1:0]       occ_m1;
	logic                is_full;
	logic                is_empty;
	cell_mode_t          mode;
	logic [IW-1:0]       pos;
	logic [STATUS_W-1:0] stat;
	logic                empty_pop;
	cell_ctrl_t          ctrl;
	logic                in_fire;
	logic                s2_free;
	logic                s1_adv;

	logic [WORD_W-1:0] words [DEPTH];
	logic [WORD_W-1:0] taps  [DEPTH];
	logic [WORD_W-1:0] grp   [NG];

	logic                valid_s1;
	logic [WORD_W-1:0]   grp_s1 [NG];
	logic [STATUS_W-1:0] status_s1;
	logic                empty_s1;
	logic [WORD_W-1:0]   tree_out;

	logic                valid_s2;
	logic [WORD_W-1:0]   value_s2;
	logic [STATUS_W-1:0] status_s2;

	assign is_full  = (occ_q == OW'(DEPTH));
	assign is_empty = (occ_q == '0);
	assign occ_m1   = occ_q - OW'(1);

	always_comb begin
		mode      = CELL_HOLD;
		pos       = '0;
		occ_next  = occ_q;
		stat      = ST_OK;
		empty_pop = 1'b0;
		unique case (operation)
			OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
				if (is_full) begin
					stat = ST_FULL;
				end else begin
					mode     = CELL_INSERT;
					occ_next = occ_q + OW'(1);
					if (operation == OP_PUSH_MIDDLE) begin
						pos = IW'(occ_q >> 1);
					end else if (operation == OP_PUSH_BACK) begin
						pos = IW'(occ_q);
					end
				end
			end
			OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
				if (is_empty) begin
					stat      = ST_EMPTY;
					empty_pop = 1'b1;
				end else begin
					mode     = CELL_REMOVE;
					occ_next = occ_m1;
					if (operation == OP_POP_MIDDLE) begin
						pos = IW'(occ_m1 >> 1);
					end else if (operation == OP_POP_BACK) begin
						pos = IW'(occ_m1);
					end
				end
			end
			default: begin
				mode = CELL_HOLD;
			end
		endcase
	end

	// Handshake: the middle stage moves whenever the output register is free.
	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_adv   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		ctrl.mode = in_fire ? mode : CELL_HOLD;
		ctrl.word = push_value;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end
		fmbq_cell #(
			.IDX_W (IW),
			.IDX   (i)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.pos   (pos),
			.left  (left_w),
			.right (right_w),
			.word  (words[i]),
			.tap   (taps[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < DEPTH) begin
					grp[g] = grp[g] | taps[g * GROUP_SIZE + k];
				end
			end
		end
	end

	always_comb begin
		tree_out = '0;
		for (int g = 0; g < NG; g++) begin
			tree_out = tree_out | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				occ_q    <= occ_next;
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			grp_s1    <= grp;
			status_s1 <= stat;
			empty_s1  <= empty_pop;
		end
		if (s1_adv) begin
			value_s2  <= empty_s1 ? '1 : tree_out;
			status_s2 <= status_s1;
		end
	end

	assign out_valid = valid_s2;
	assign pop_value = value_s2;
	assign status    = status_s2;

endmodule
`default_nettype wire

### design/fmbq_checker.sv
// Port-level checks of the queue's result channel and input stall, bound to the top level.
`default_nettype none
module fmbq_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [fmbq_pkg::WORD_W-1:0]   pop_value,
	input wire logic        [fmbq_pkg::STATUS_W-1:0] status
);
	import fmbq_pkg::*;

	// On a valid result the status code is one of the three defined outcomes.
	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
		else $error("undefined status code on a result");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (pop_value == '1))
		else $error("pop on empty queue did not return all ones");

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (pop_value == '0))
		else $error("dropped push returned a nonzero value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pop_value) && $stable(status)))
		else $error("stalled result changed");

	// With input stalled a result must be pending and held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

endmodule

bind front_middle_back_queue_top fmbq_checker u_fmbq_checker (.*);
`default_nettype wire
